FILE: rtl/core/mtp_pkg.sv
// Shared types, constants and lookup tables for the MIDI tone-period frame core.
`default_nettype none
package mtp_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W     = 4;

	// MIDI event nibbles and controller numbers
	localparam logic [3:0] EV_NOTE_OFF = 4'h8;
	localparam logic [3:0] EV_NOTE_ON  = 4'h9;
	localparam logic [3:0] EV_CONTROL  = 4'hB;
	localparam logic [3:0] EV_BEND     = 4'hE;
	localparam logic [6:0] CC_ALL_OFF  = 7'd123;

	// configuration registers
	localparam logic       REG_MIN_PERIOD = 1'b0;
	localparam logic       REG_BEND_RANGE = 1'b1;
	localparam logic [15:0] MIN_PERIOD_RESET = 16'd2841;
	localparam logic [11:0] BEND_RANGE_RESET = 12'd200;

	// bend exponent: floor((75 - c*p) / 150), made positive by a bias of 150 * 2^20
	localparam int NUM_W   = 28;
	localparam logic [NUM_W:0] NUM_OFFSET = 29'd157286475;
	// floor(n / 150) = ((n >> 1) * ceil(2^34 / 75)) >> 34, exact for n below 2^28
	localparam logic [27:0] DIV_RECIP = 28'd229064923;
	localparam logic [17:0] M_ONE = 18'd65536;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] data_one;
		logic [6:0] data_two;
	} msg_t;

	typedef struct packed {
		logic [4:0]  drive_channel;
		logic [15:0] period_ticks;
		logic        last_in_run;
	} frame_t;

	typedef enum logic [1:0] {
		OP_NOTE_OFF,
		OP_NOTE_ON,
		OP_MUTE_ALL,
		OP_BEND
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [CH_W-1:0] slot;
		logic [6:0]      data_one;
		logic [6:0]      data_two;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NOTE,
		ST_EMIT,
		ST_MUTE,
		ST_BEND_MUL,
		ST_BEND_DIV,
		ST_BEND_ROOT,
		ST_BEND_SCALE,
		ST_BEND_SHIFT
	} state_t;

	// octave ROM, note periods of keys 0..11 in Q.12
	function automatic logic [29:0] note_rom(input logic [3:0] key);
		logic [29:0] v;
		case (key)
			4'd0:    v = 30'd626242246;
			4'd1:    v = 30'd591093970;
			4'd2:    v = 30'd557918414;
			4'd3:    v = 30'd526604859;
			4'd4:    v = 30'd497048800;
			4'd5:    v = 30'd469151594;
			4'd6:    v = 30'd442820138;
			4'd7:    v = 30'd417966554;
			4'd8:    v = 30'd394507894;
			4'd9:    v = 30'd372365868;
			4'd10:   v = 30'd351466572;
			4'd11:   v = 30'd331740273;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// round(65536 * 2^(2^-i)) for i = 1..16
	function automatic logic [16:0] root_rom(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd1:    v = 17'd92682;
			5'd2:    v = 17'd77936;
			5'd3:    v = 17'd71468;
			5'd4:    v = 17'd68438;
			5'd5:    v = 17'd66971;
			5'd6:    v = 17'd66250;
			5'd7:    v = 17'd65892;
			5'd8:    v = 17'd65714;
			5'd9:    v = 17'd65625;
			5'd10:   v = 17'd65580;
			5'd11:   v = 17'd65558;
			5'd12:   v = 17'd65547;
			5'd13:   v = 17'd65542;
			5'd14:   v = 17'd65539;
			5'd15:   v = 17'd65537;
			5'd16:   v = 17'd65537;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

	// half-period ticks of a note, saturated to 16 bits
	function automatic logic [15:0] note_period(input logic [6:0] note);
		logic [14:0] prod;
		logic [3:0]  oct;
		logic [7:0]  oct12;
		logic [3:0]  key;
		logic [30:0] sum;
		logic [30:0] v;
		prod  = 15'(note) * 15'd171;
		oct   = prod[14:11];
		oct12 = 8'(oct) * 8'd12;
		key   = 4'(8'(note) - oct12);
		sum   = 31'(note_rom(key)) + (31'(1) << (5'd11 + 5'(oct)));
		v     = sum >> (5'd12 + 5'(oct));
		return (v > 31'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtp_front.sv
// Message decoder: classifies each MIDI message into a back-end command.
`default_nettype none
module mtp_front (
	input  wire mtp_pkg::msg_t msg,
	input  wire                msg_valid,
	input  wire                full,
	output logic               push,
	output mtp_pkg::cmd_t      cmd
);

	logic [3:0] ev;
	logic [3:0] nib;
	logic       ok;
	logic       useful;

	always_comb begin
		ev  = msg.status_byte[7:4];
		nib = msg.status_byte[3:0];
		ok  = int'(nib) < mtp_pkg::CHANNELS;
		cmd.slot     = nib[mtp_pkg::CH_W-1:0];
		cmd.data_one = msg.data_one;
		cmd.data_two = msg.data_two;
		cmd.op       = mtp_pkg::OP_NOTE_OFF;
		useful       = 1'b0;
		case (ev)
			mtp_pkg::EV_NOTE_OFF: begin
				useful = ok;
			end
			mtp_pkg::EV_NOTE_ON: begin
				useful = ok;
				cmd.op = (msg.data_two == 7'd0) ? mtp_pkg::OP_NOTE_OFF : mtp_pkg::OP_NOTE_ON;
			end
			mtp_pkg::EV_CONTROL: begin
				useful = (msg.data_one == mtp_pkg::CC_ALL_OFF);
				cmd.op = mtp_pkg::OP_MUTE_ALL;
			end
			mtp_pkg::EV_BEND: begin
				useful = ok;
				cmd.op = mtp_pkg::OP_BEND;
			end
			default: begin
				useful = 1'b0;
			end
		endcase
		// drop messages with no back-end command; hold the rest until the queue has room
		push = msg_valid && !full && useful;
	end

endmodule
`default_nettype wire

FILE: rtl/core/mtp_queue.sv
// Two-entry command queue between decoder and executor.
`default_nettype none
module mtp_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire mtp_pkg::cmd_t push_cmd,
	input  wire                pop,
	output logic               full,
	output logic               pop_valid,
	output mtp_pkg::cmd_t      pop_cmd
);

	mtp_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		full      = (count_q == 2'd2);
		pop_valid = (count_q != 2'd0);
		pop_cmd   = entry_q[rd_ptr_q];
		do_push   = push && !full;
		do_pop    = pop && pop_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

FILE: rtl/core/mtp_back.sv
// Command executor: note lookup, bend scaling, channel state and frame output register.
`default_nettype none
module mtp_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_valid,
	input  wire mtp_pkg::cmd_t q_cmd,
	output logic               pop,
	input  wire  [15:0]        min_period,
	input  wire  [11:0]        bend_cents,
	output logic               frame_valid,
	input  wire                frame_stall,
	output mtp_pkg::frame_t    frame
);

	mtp_pkg::state_t state_q, state_nx;
	mtp_pkg::cmd_t   cmd_q;
	mtp_pkg::frame_t frame_q;
	logic            frame_valid_q;
	logic [15:0]     base_q [mtp_pkg::CHANNELS];
	logic [mtp_pkg::CH_W-1:0] mute_q;
	logic [15:0]     res_q;
	logic            keep_q;
	logic [mtp_pkg::NUM_W-1:0] num_q;
	logic [4:0]      cnt_q;
	logic [4:0]      shift_q;
	logic [17:0]     m_q;
	logic [33:0]     prod_q;

	logic            free;
	logic            emit;
	logic            mute_last;
	logic [15:0]     base_rd;
	logic signed [13:0] wheel;
	logic signed [26:0] cp;
	logic [mtp_pkg::NUM_W:0] num_init;
	logic [54:0]     quot_full;
	logic [20:0]     quot;
	logic [16:0]     root;
	logic [34:0]     mr;
	logic [34:0]     rnd;
	logic [34:0]     bent;
	logic [15:0]     bent_sat;
	logic [15:0]     note_per;

	always_comb begin
		free      = !frame_valid_q || !frame_stall;
		mute_last = (mute_q == mtp_pkg::CH_W'(mtp_pkg::CHANNELS - 1));
		base_rd   = base_q[cmd_q.slot];
		// wheel minus center is the wheel with its top bit flipped, read as signed
		wheel     = $signed({~cmd_q.data_two[6], cmd_q.data_two[5:0], cmd_q.data_one});
		cp        = $signed({1'b0, bend_cents}) * wheel;
		num_init  = mtp_pkg::NUM_OFFSET - unsigned'((mtp_pkg::NUM_W+1)'(cp));
		quot_full = 55'(num_q[mtp_pkg::NUM_W-1:1]) * 55'(mtp_pkg::DIV_RECIP);
		quot      = quot_full[54:34];
		root      = num_q[15] ? mtp_pkg::root_rom(cnt_q) : 17'd65536;
		mr        = 35'(m_q) * 35'(root) + 35'd32768;
		rnd       = 35'(prod_q) + (35'(1) << (shift_q - 5'd1));
		bent      = rnd >> shift_q;
		bent_sat  = (bent > 35'd65535) ? 16'hFFFF : bent[15:0];
		note_per  = mtp_pkg::note_period(cmd_q.data_one);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			mtp_pkg::ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						mtp_pkg::OP_MUTE_ALL: state_nx = mtp_pkg::ST_MUTE;
						mtp_pkg::OP_BEND:     state_nx = mtp_pkg::ST_BEND_MUL;
						default:              state_nx = mtp_pkg::ST_NOTE;
					endcase
				end
			end
			mtp_pkg::ST_NOTE:       state_nx = mtp_pkg::ST_EMIT;
			mtp_pkg::ST_EMIT: begin
				if (!keep_q || free) state_nx = mtp_pkg::ST_IDLE;
			end
			mtp_pkg::ST_MUTE: begin
				if (free && mute_last) state_nx = mtp_pkg::ST_IDLE;
			end
			mtp_pkg::ST_BEND_MUL: begin
				state_nx = (base_rd == 16'd0) ? mtp_pkg::ST_EMIT : mtp_pkg::ST_BEND_DIV;
			end
			mtp_pkg::ST_BEND_DIV:   state_nx = mtp_pkg::ST_BEND_ROOT;
			mtp_pkg::ST_BEND_ROOT: begin
				if (cnt_q == 5'd16) state_nx = mtp_pkg::ST_BEND_SCALE;
			end
			mtp_pkg::ST_BEND_SCALE: state_nx = mtp_pkg::ST_BEND_SHIFT;
			mtp_pkg::ST_BEND_SHIFT: state_nx = mtp_pkg::ST_EMIT;
			default:                state_nx = mtp_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		case (state_q)
			mtp_pkg::ST_IDLE: pop  = q_valid;
			mtp_pkg::ST_EMIT: emit = keep_q && free;
			mtp_pkg::ST_MUTE: emit = free;
			default: begin
				pop  = 1'b0;
				emit = 1'b0;
			end
		endcase
	end

	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= mtp_pkg::ST_IDLE;
			frame_valid_q <= 1'b0;
			mute_q        <= '0;
			for (int i = 0; i < mtp_pkg::CHANNELS; i++) base_q[i] <= 16'd0;
		end else begin
			state_q <= state_nx;
			if (emit) begin
				frame_valid_q <= 1'b1;
			end else if (!frame_stall) begin
				frame_valid_q <= 1'b0;
			end
			if (emit && state_q == mtp_pkg::ST_MUTE) begin
				base_q[mute_q] <= 16'd0;
				mute_q         <= mute_last ? '0 : mute_q + 1'b1;
			end
			if (emit && state_q == mtp_pkg::ST_EMIT && cmd_q.op != mtp_pkg::OP_BEND) begin
				base_q[cmd_q.slot] <= res_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= q_cmd;
		if (emit) begin
			if (state_q == mtp_pkg::ST_MUTE) begin
				frame_q.drive_channel <= 5'(mute_q) + 5'd1;
				frame_q.period_ticks  <= 16'd0;
				frame_q.last_in_run   <= mute_last;
			end else begin
				frame_q.drive_channel <= 5'(cmd_q.slot) + 5'd1;
				frame_q.period_ticks  <= res_q;
				frame_q.last_in_run   <= 1'b1;
			end
		end
		case (state_q)
			mtp_pkg::ST_NOTE: begin
				if (cmd_q.op == mtp_pkg::OP_NOTE_OFF) begin
					res_q  <= 16'd0;
					keep_q <= 1'b1;
				end else begin
					res_q  <= note_per;
					keep_q <= (note_per >= min_period);
				end
			end
			mtp_pkg::ST_BEND_MUL: begin
				// a silent channel answers with period zero; else carry the base along
				res_q  <= base_rd;
				keep_q <= 1'b1;
				num_q  <= num_init[mtp_pkg::NUM_W-1:0];
			end
			mtp_pkg::ST_BEND_DIV: begin
				// shift = 16 - (quotient[20:16] - 16)
				num_q   <= mtp_pkg::NUM_W'(quot);
				shift_q <= 5'd0 - quot[20:16];
				m_q     <= mtp_pkg::M_ONE;
				cnt_q   <= 5'd1;
			end
			mtp_pkg::ST_BEND_ROOT: begin
				m_q   <= mr[33:16];
				num_q <= {num_q[mtp_pkg::NUM_W-2:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
			end
			mtp_pkg::ST_BEND_SCALE: begin
				prod_q <= 34'(res_q) * 34'(m_q);
			end
			mtp_pkg::ST_BEND_SHIFT: begin
				res_q  <= bent_sat;
				keep_q <= (bent_sat >= min_period);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/midi_to_tone_period_frames_core.sv
// Top level: MIDI message in, tone-period frames out, APB configuration registers.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  msg     | in        | msg_valid/stall   | mtp_pkg::msg_t (status, data one, two)
//  frame   | out       | frame_valid/stall | mtp_pkg::frame_t (channel, period, last)
//  apb     | in/out    | psel/penable      | 0x0 min_period_ticks, 0x4 bend_range_cents
//
// A note message passes queue pop, ROM lookup and output register before its
// frame is presented. A pitch bend passes pop, exponent product, one reciprocal
// multiply for the divide by 150, 16 steps of the mantissa chain (one root
// factor per cycle), scale, round and output register; on a silent channel it
// goes from the product straight to the output register. Control 123 sends
// one frame per cycle for all 16 channels while the output is not stalled.
// Reset clears channel bases, queue and sequencer at once; no clearing pass.
// A stalled frame holds in the output register while the queue keeps taking
// messages; msg_stall rises only when both queue entries are in use.
`default_nettype none
module midi_to_tone_period_frames_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  msg_valid,
	output logic                 msg_stall,
	input  wire mtp_pkg::msg_t   msg,
	output logic                 frame_valid,
	input  wire                  frame_stall,
	output mtp_pkg::frame_t      frame,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [2:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [15:0]   min_period_q;
	logic [11:0]   bend_range_q;
	logic          full;
	logic          push;
	mtp_pkg::cmd_t push_cmd;
	logic          pop;
	logic          pop_valid;
	mtp_pkg::cmd_t pop_cmd;
	logic          wr_en;

	assign pready    = 1'b1;
	assign msg_stall = full;
	assign wr_en     = psel && penable && pwrite;

	// register read: word index is address bit 2
	always_comb begin
		case (paddr[2])
			mtp_pkg::REG_MIN_PERIOD: prdata = {16'd0, min_period_q};
			mtp_pkg::REG_BEND_RANGE: prdata = {20'd0, bend_range_q};
			default:                 prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= mtp_pkg::MIN_PERIOD_RESET;
			bend_range_q <= mtp_pkg::BEND_RANGE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				mtp_pkg::REG_MIN_PERIOD: min_period_q <= pwdata[15:0];
				mtp_pkg::REG_BEND_RANGE: bend_range_q <= pwdata[11:0];
				default:                 min_period_q <= min_period_q;
			endcase
		end
	end

	mtp_front u_front (
		.msg       (msg),
		.msg_valid (msg_valid),
		.full      (full),
		.push      (push),
		.cmd       (push_cmd)
	);

	mtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (full),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	mtp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (pop_valid),
		.q_cmd       (pop_cmd),
		.pop         (pop),
		.min_period  (min_period_q),
		.bend_cents  (bend_range_q),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

endmodule
`default_nettype wire
